// File: sv/bgi_pkg.sv
package bgi_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int VAL_AW     = 2 * IDX_W;
  localparam int GRID_W     = 16;
  localparam int VAL_W      = 32;
  localparam int CFG_W      = 6;
  localparam int CFG_RESET  = 32;
  localparam int MIN_POINTS = 4;

  // data word of the input stream, fields from the lowest bit up
  localparam int ROW_LSB    = 0;
  localparam int COL_LSB    = ROW_LSB + IDX_W;
  localparam int PX_LSB     = COL_LSB + IDX_W;
  localparam int PY_LSB     = PX_LSB + GRID_W;
  localparam int LOAD_LSB   = PY_LSB + GRID_W;
  localparam int IN_BITS    = LOAD_LSB + VAL_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // spline arithmetic
  localparam int GAP_MIN    = 7;
  localparam int ONE_Q16    = 65536;
  localparam int U_CAP      = 262144;
  localparam int U_W        = 19;
  localparam int CW         = 54;
  localparam int HW         = 58;
  localparam int PH_W       = CW - 16 + U_W;
  localparam int PL_W       = 16 + U_W;
  localparam longint STAGE_LIM = 64'h000F_FFFF_FFFF_FFFF;

  // shared divider
  localparam int DVN_W      = 49;
  localparam int DVD_W      = 18;
  localparam int CNT_W      = $clog2(DVN_W + 1);

  typedef enum logic [1:0] {
    MODE_GRID = 2'd0,
    MODE_VAL  = 2'd1,
    MODE_EVAL = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WR_GRID,
    OP_WR_VAL,
    OP_START,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_GRID_RD,
    OP_VAL_RD,
    OP_U_START,
    OP_U_SET,
    OP_YLOAD,
    OP_GAPS,
    OP_MUL,
    OP_DIV_START,
    OP_ACC,
    OP_COEF,
    OP_HMUL,
    OP_HADD,
    OP_STORE_YV,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
    logic [1:0] col;
    logic       axis_y;
  } cmd_t;

  typedef struct packed {
    logic srch_end;
    logic div_busy;
  } sts_t;

endpackage

// File: sv/bgi_ram.sv
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bgi_div.sv
module bgi_div import bgi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVN_W-1:0] dividend_i,
  input  logic [DVD_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVN_W-1:0] quotient_o
);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] rem_q, rem_d;
  logic [DVN_W-1:0] quo_q, quo_d;
  logic [DVD_W-1:0] dvs_q, dvs_d;
  logic [DVD_W:0]   sh, sub;
  logic             ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    sh     = {rem_q, quo_q[DVN_W-1]};
    sub    = sh - {1'b0, dvs_q};
    ge     = sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVN_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? sub[DVD_W-1:0] : sh[DVD_W-1:0];
      quo_d = {quo_q[DVN_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> rem_q < dvs_q)
    else $error("remainder not below divisor at end of division");

  a_dvs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> dvs_q != '0)
    else $error("division by zero in progress");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

// File: sv/bgi_datapath.sv
module bgi_datapath import bgi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [CFG_W-1:0]  cfg_points_i,
  input  logic [IDX_W-1:0]  in_row_i,
  input  logic [IDX_W-1:0]  in_col_i,
  input  logic [GRID_W-1:0] in_px_i,
  input  logic [GRID_W-1:0] in_py_i,
  input  logic [VAL_W-1:0]  in_load_i,
  output sts_t              sts_o,
  output logic [VAL_W-1:0]  density_o
);

  function automatic logic [IDX_W-1:0] cell_pick(input logic [IDX_W-1:0] c,
                                                 input logic [1:0] slot,
                                                 input logic [IDX_W-1:0] last);
    logic [IDX_W:0] c2;
    c2 = {1'b0, c} + (IDX_W+1)'(2);
    case (slot)
      2'd0:    cell_pick = (c == '0) ? c : c - IDX_W'(1);
      2'd1:    cell_pick = c;
      2'd2:    cell_pick = c + IDX_W'(1);
      default: cell_pick = (c2 > {1'b0, last}) ? last : c2[IDX_W-1:0];
    endcase
  endfunction

  function automatic logic signed [CW-1:0] vext(input logic [VAL_W-1:0] v);
    vext = $signed({{(CW-VAL_W){1'b0}}, v});
  endfunction

  // points in use, clamped
  logic [CFG_W-1:0] m_pts;
  logic [IDX_W-1:0] m_last;

  always_comb begin
    if (cfg_points_i < CFG_W'(MIN_POINTS)) begin
      m_pts = CFG_W'(MIN_POINTS);
    end else if (cfg_points_i > CFG_W'(MAX_POINTS)) begin
      m_pts = CFG_W'(MAX_POINTS);
    end else begin
      m_pts = cfg_points_i;
    end
    m_last = IDX_W'(m_pts - CFG_W'(1));
  end

  // state
  logic [GRID_W-1:0] px_q, py_q;
  logic [IDX_W-1:0]  ci_q, cj_q, k_q;
  logic              fi_q, fj_q;
  logic [GRID_W-1:0] g_q [4];
  logic [VAL_W-1:0]  v_q [4];
  logic [VAL_W-1:0]  yv_q [4];
  logic [U_W-1:0]    u_q;
  logic              u_zero_q;
  logic [GRID_W:0]   d0_q, d1_q, d2_q;
  logic signed [CW-1:0] t1_q, t2_q, a2_q, r_q;
  logic [DVN_W-1:0]  n_mag_q;
  logic              n_neg_q;
  logic [DVD_W-1:0]  dvs_q;
  logic [PH_W-1:0]   ph_q;
  logic [PL_W-1:0]   pl_q;
  logic              hneg_q;
  logic              gpend_q, vpend_q;
  logic [1:0]        pslot_q;

  // memories
  logic [IDX_W-1:0]  grid_raddr, cell_sel, col_sel;
  logic [GRID_W-1:0] grid_rdata;
  logic [VAL_W-1:0]  val_rdata;
  logic [IDX_W:0]    cs, cs1;

  always_comb begin
    cell_sel   = cell_pick(cmd_i.axis_y ? cj_q : ci_q, cmd_i.idx, m_last);
    grid_raddr = (cmd_i.op == OP_SRCH_RD) ? k_q : cell_sel;
    cs  = {1'b0, cj_q} + (IDX_W+1)'(cmd_i.col);
    cs1 = cs - (IDX_W+1)'(1);
    if (cs == '0) begin
      col_sel = '0;
    end else if (cs1 > {1'b0, m_last}) begin
      col_sel = m_last;
    end else begin
      col_sel = cs1[IDX_W-1:0];
    end
  end

  bgi_ram #(.WIDTH(GRID_W), .DEPTH(MAX_POINTS)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_WR_GRID),
    .waddr_i (in_row_i),
    .wdata_i (in_load_i[GRID_W-1:0]),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  bgi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_WR_VAL),
    .waddr_i ({in_row_i, in_col_i}),
    .wdata_i (in_load_i),
    .raddr_i ({cell_pick(ci_q, cmd_i.idx, m_last), col_sel}),
    .rdata_o (val_rdata)
  );

  // cell position
  logic [GRID_W-1:0] xs, unum, uspan;
  logic              uvalid;
  logic [DVN_W-1:0]  udvn;

  always_comb begin
    xs     = cmd_i.axis_y ? py_q : px_q;
    uvalid = (xs > g_q[1]) && (g_q[2] > g_q[1]);
    unum   = xs - g_q[1];
    uspan  = g_q[2] - g_q[1];
    udvn   = DVN_W'({unum, 16'h0000}) + DVN_W'(uspan >> 1);
  end

  // gaps with repair of near repeated points
  logic signed [GRID_W:0] d0s, d1s, d2s;
  logic [GRID_W:0]        d0r, d1r, d2r;

  always_comb begin
    d0s = $signed({1'b0, g_q[1]}) - $signed({1'b0, g_q[0]});
    d1s = $signed({1'b0, g_q[2]}) - $signed({1'b0, g_q[1]});
    d2s = $signed({1'b0, g_q[3]}) - $signed({1'b0, g_q[2]});
    d1r = (d1s < $signed((GRID_W+1)'(GAP_MIN))) ? (GRID_W+1)'(ONE_Q16) : d1s;
    d0r = (d0s < $signed((GRID_W+1)'(GAP_MIN))) ? d1r : d0s;
    d2r = (d2s < $signed((GRID_W+1)'(GAP_MIN))) ? d1r : d2s;
  end

  // tangent terms: difference times d1, divisor per term
  logic [VAL_W-1:0]               va, vb;
  logic signed [VAL_W:0]          vdiff;
  logic signed [VAL_W+GRID_W+2:0] nprod, nmag;
  logic [DVD_W-1:0]               dvs_sel;

  always_comb begin
    case (cmd_i.idx)
      2'd0: begin
        va = v_q[1]; vb = v_q[0];
        dvs_sel = DVD_W'(d0_q);
      end
      2'd1: begin
        va = v_q[2]; vb = v_q[0];
        dvs_sel = DVD_W'(d0_q) + DVD_W'(d1_q);
      end
      2'd2: begin
        va = v_q[3]; vb = v_q[1];
        dvs_sel = DVD_W'(d1_q) + DVD_W'(d2_q);
      end
      default: begin
        va = v_q[3]; vb = v_q[2];
        dvs_sel = DVD_W'(d2_q);
      end
    endcase
    vdiff = $signed({1'b0, va}) - $signed({1'b0, vb});
    nprod = vdiff * $signed({1'b0, d1_q});
    nmag  = nprod[VAL_W+GRID_W+2] ? -nprod : nprod;
  end

  // divider
  logic             div_start, div_busy;
  logic [DVN_W-1:0] div_dvn, quo;
  logic [DVD_W-1:0] div_dvs;

  always_comb begin
    div_start = (cmd_i.op == OP_U_START) || (cmd_i.op == OP_DIV_START);
    if (cmd_i.op == OP_U_START) begin
      div_dvn = udvn;
      div_dvs = uvalid ? DVD_W'(uspan) : DVD_W'(1);
    end else begin
      div_dvn = n_mag_q + DVN_W'(dvs_q >> 1);
      div_dvs = dvs_q;
    end
  end

  bgi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvn),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // coefficients and horner step
  logic signed [CW-1:0] sq, dv, coef;
  logic [CW-1:0]        rmag;
  logic [PL_W-1:0]      plr;
  logic [HW-1:0]        p;
  logic signed [HW-1:0] sp, hsum, hlim;
  logic [VAL_W-1:0]     rclamp;

  always_comb begin
    sq   = $signed(CW'(quo));
    sq   = n_neg_q ? -sq : sq;
    dv   = vext(v_q[2]) - vext(v_q[1]);
    case (cmd_i.idx)
      2'd0:    coef = a2_q;
      2'd1:    coef = t1_q;
      default: coef = vext(v_q[1]);
    endcase
    rmag = r_q[CW-1] ? -r_q : r_q;
    plr  = (pl_q + PL_W'(32768)) >> 16;
    p    = HW'(ph_q) + HW'(plr);
    sp   = hneg_q ? -$signed(p) : $signed(p);
    hsum = sp + $signed({{(HW-CW){coef[CW-1]}}, coef});
    hlim = $signed(HW'(STAGE_LIM));
    if (r_q[CW-1]) begin
      rclamp = '0;
    end else if (|r_q[CW-2:VAL_W]) begin
      rclamp = '1;
    end else begin
      rclamp = r_q[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpend_q <= 1'b0;
      vpend_q <= 1'b0;
    end else begin
      gpend_q <= (cmd_i.op == OP_GRID_RD);
      vpend_q <= (cmd_i.op == OP_VAL_RD);
    end
  end

  always_ff @(posedge clk_i) begin
    pslot_q <= cmd_i.idx;
    if (gpend_q) begin
      g_q[pslot_q] <= grid_rdata;
    end
    if (vpend_q) begin
      v_q[pslot_q] <= val_rdata;
    end
    case (cmd_i.op)
      OP_START: begin
        px_q <= in_px_i;
        py_q <= in_py_i;
        ci_q <= '0;
        cj_q <= '0;
        fi_q <= 1'b0;
        fj_q <= 1'b0;
        k_q  <= IDX_W'(1);
      end
      OP_SRCH_CMP: begin
        if (px_q >= grid_rdata) ci_q <= k_q; else fi_q <= 1'b1;
        if (py_q >= grid_rdata) cj_q <= k_q; else fj_q <= 1'b1;
        k_q <= k_q + IDX_W'(1);
      end
      OP_U_START: u_zero_q <= !uvalid;
      OP_U_SET: begin
        if (u_zero_q) begin
          u_q <= '0;
        end else if (quo > DVN_W'(U_CAP)) begin
          u_q <= U_W'(U_CAP);
        end else begin
          u_q <= quo[U_W-1:0];
        end
      end
      OP_YLOAD: v_q <= yv_q;
      OP_GAPS: begin
        d0_q <= d0r;
        d1_q <= d1r;
        d2_q <= d2r;
        t1_q <= dv;
        t2_q <= dv;
      end
      OP_MUL: begin
        n_neg_q <= nprod[VAL_W+GRID_W+2];
        n_mag_q <= DVN_W'(nmag);
        dvs_q   <= dvs_sel;
      end
      OP_ACC: begin
        case (cmd_i.idx)
          2'd0:    t1_q <= t1_q + sq;
          2'd1:    t1_q <= t1_q - sq;
          2'd2:    t2_q <= t2_q - sq;
          default: t2_q <= t2_q + sq;
        endcase
      end
      OP_COEF: begin
        a2_q <= (dv <<< 1) + dv - (t1_q <<< 1) - t2_q;
        r_q  <= t1_q + t2_q - (dv <<< 1);
      end
      OP_HMUL: begin
        hneg_q <= r_q[CW-1];
        ph_q   <= PH_W'(rmag[CW-1:16]) * PH_W'(u_q);
        pl_q   <= PL_W'(rmag[15:0]) * PL_W'(u_q);
      end
      OP_HADD: begin
        if (hsum > hlim) begin
          r_q <= CW'(hlim);
        end else if (hsum < -hlim) begin
          r_q <= CW'(-hlim);
        end else begin
          r_q <= CW'(hsum);
        end
      end
      OP_STORE_YV: yv_q[cmd_i.idx] <= rclamp;
      default: ;
    endcase
  end

  assign sts_o.srch_end = (fi_q && fj_q) || (k_q >= m_last);
  assign sts_o.div_busy = div_busy;
  assign density_o      = (rclamp == '0) ? VAL_W'(1) : rclamp;

endmodule

// File: sv/bgi_ctrl.sv
module bgi_ctrl import bgi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  input  logic       out_free_i,
  input  sts_t       sts_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_SCMP, S_GRD, S_GWAIT, S_USTART, S_UWAIT, S_VRD, S_VWAIT,
    S_YLOAD, S_GAPS, S_MUL, S_DSTART, S_DWAIT, S_COEF, S_HMUL, S_HADD, S_FIN, S_RES
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d, s_q, s_d;
  logic       axis_q, axis_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    s_d     = s_q;
    axis_d  = axis_q;
    cmd_o   = '{op: OP_NONE, idx: cnt_q, col: s_q, axis_y: axis_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_mode_i)
            MODE_GRID: cmd_o.op = OP_WR_GRID;
            MODE_VAL:  cmd_o.op = OP_WR_VAL;
            MODE_EVAL: begin
              cmd_o.op = OP_START;
              axis_d   = 1'b0;
              s_d      = '0;
              state_d  = S_SRCH;
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (sts_i.srch_end) begin
          cnt_d   = '0;
          state_d = S_GRD;
        end else begin
          cmd_o.op = OP_SRCH_RD;
          state_d  = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd_o.op = OP_SRCH_CMP;
        state_d  = S_SRCH;
      end
      S_GRD: begin
        cmd_o.op = OP_GRID_RD;
        cnt_d    = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = S_GWAIT;
      end
      S_GWAIT: state_d = S_USTART;
      S_USTART: begin
        cmd_o.op = OP_U_START;
        state_d  = S_UWAIT;
      end
      S_UWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_U_SET;
          cnt_d    = '0;
          state_d  = axis_q ? S_YLOAD : S_VRD;
        end
      end
      S_VRD: begin
        cmd_o.op = OP_VAL_RD;
        cnt_d    = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = S_VWAIT;
      end
      S_VWAIT: state_d = S_GAPS;
      S_YLOAD: begin
        cmd_o.op = OP_YLOAD;
        state_d  = S_GAPS;
      end
      S_GAPS: begin
        cmd_o.op = OP_GAPS;
        cnt_d    = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.op = OP_DIV_START;
        state_d  = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_ACC;
          cnt_d    = cnt_q + 2'd1;
          state_d  = (cnt_q == 2'd3) ? S_COEF : S_MUL;
        end
      end
      S_COEF: begin
        cmd_o.op = OP_COEF;
        cnt_d    = '0;
        state_d  = S_HMUL;
      end
      S_HMUL: begin
        cmd_o.op = OP_HMUL;
        state_d  = S_HADD;
      end
      S_HADD: begin
        cmd_o.op = OP_HADD;
        cnt_d    = cnt_q + 2'd1;
        state_d  = (cnt_q == 2'd2) ? S_FIN : S_HMUL;
      end
      S_FIN: begin
        cnt_d = '0;
        if (axis_q) begin
          state_d = S_RES;
        end else begin
          cmd_o.op  = OP_STORE_YV;
          cmd_o.idx = s_q;
          s_d       = s_q + 2'd1;
          if (s_q == 2'd3) begin
            axis_d  = 1'b1;
            state_d = S_GRD;
          end else begin
            state_d = S_VRD;
          end
        end
      end
      S_RES: begin
        if (out_free_i) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      s_q     <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      s_q     <= s_d;
      axis_q  <= axis_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_DIV_START || cmd_o.op == OP_U_START) |=> sts_i.div_busy)
    else $error("divider did not start");

  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_RESULT |-> out_free_i)
    else $error("result written over a waiting result");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts_i.div_busy)
    else $error("input taken while divider busy");

endmodule

// File: sv/bicubic_grid_interpolator.sv
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: mode; tdata: row, col, x, y, load
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: density
// cfg       | in  | cfg_we_i                     | cfg_wdata_i: points in use
//
// an evaluate runs on the shared one-bit-a-cycle divider: 4 divisions for
// each of five splines plus one position division per axis, after a cell
// search over the grid points
// input is taken only while the controller is idle; a finished result waits
// in the output register while the next item is taken
// reset sets points in use to 32; grid and table contents are undefined until loaded
module bicubic_grid_interpolator import bgi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // row_index, col_index, point_x, point_y, load_value
  input  logic [1:0]            s_axis_tuser,  // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VAL_W-1:0]      m_axis_tdata,  // density
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  logic [CFG_W-1:0] points_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_data_q;
  logic [VAL_W-1:0] density;
  logic             out_free;
  cmd_t             cmd;
  sts_t             sts;

  assign out_free = !out_valid_q || m_axis_tready;

  bgi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  bgi_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_points_i (points_q),
    .in_row_i     (s_axis_tdata[ROW_LSB +: IDX_W]),
    .in_col_i     (s_axis_tdata[COL_LSB +: IDX_W]),
    .in_px_i      (s_axis_tdata[PX_LSB +: GRID_W]),
    .in_py_i      (s_axis_tdata[PY_LSB +: GRID_W]),
    .in_load_i    (s_axis_tdata[LOAD_LSB +: VAL_W]),
    .sts_o        (sts),
    .density_o    (density)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q    <= CFG_W'(CFG_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        points_q <= cfg_wdata_i;
      end
      if (cmd.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.op == OP_RESULT) begin
      out_data_q <= density;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
